/* hw/rtl/akx_pkg.sv */
package akx_pkg;

	// key schedule geometry
	localparam int NUM_ROUNDS  = 14;
	localparam int KEY_WORDS   = 8;
	localparam int TOTAL_WORDS = 4 * (NUM_ROUNDS + 1);
	localparam int IDX_W       = $clog2(TOTAL_WORDS);
	localparam int ROW_W       = $clog2(NUM_ROUNDS + 1);
	localparam int ADDR_W      = ROW_W + 1;
	localparam int MEM_DEPTH   = 2 ** ADDR_W;

	localparam logic [IDX_W-1:0] LAST_WORD    = IDX_W'(TOTAL_WORDS - 1);
	localparam logic [IDX_W-1:0] LAST_KEY_ROW = IDX_W'(KEY_WORDS - 4);
	localparam logic [IDX_W-1:0] FIRST_GEN    = IDX_W'(KEY_WORDS);
	localparam logic [ROW_W-1:0] LAST_ROUND   = ROW_W'(NUM_ROUNDS);

	localparam logic FUNC_FWD = 1'b0;
	localparam logic FUNC_INV = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_GEN,
		ST_READ,
		ST_LOAD
	} akx_state_t;

	// controller to datapath
	typedef struct packed {
		logic             capture;
		logic             key_write;
		logic             gen_step;
		logic             mem_read;
		logic             out_load;
		logic [IDX_W-1:0] word_idx;
	} akx_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic expand_req;
	} akx_stat_t;

	// aes forward s-box
	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// multiply by x in gf(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

/* hw/rtl/akx_if.sv */
// request channel
interface akx_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [3:0]  round_index;
	logic [63:0] key_w0;
	logic [63:0] key_w1;
	logic [63:0] key_w2;
	logic [63:0] key_w3;

	modport source (
		output valid, func, round_index, key_w0, key_w1, key_w2, key_w3,
		input  ready
	);
	modport sink (
		input  valid, func, round_index, key_w0, key_w1, key_w2, key_w3,
		output ready
	);
endinterface

// response channel
interface akx_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] round_key_hi;
	logic [63:0] round_key_lo;

	modport source (
		output valid, round_key_hi, round_key_lo,
		input  ready
	);
	modport sink (
		input  valid, round_key_hi, round_key_lo,
		output ready
	);
endinterface

/* hw/rtl/aes256_round_key_expansion.sv */
// aes-256 round key expansion with forward and inverse round key stores
// a lookup reads the store in ST_READ and loads the output register in ST_LOAD, waiting there
//   until the previous result is taken; an expanding request first passes ST_KEY and ST_GEN,
//   whose key schedule loop makes one word per cycle; a new request is taken only in ST_IDLE
// reset: controller idles, both stores read as zero until their first expansion,
//   no clearing pass
module aes256_round_key_expansion (
	input logic      clk,
	input logic      arst_n,
	akx_req_if.sink  req,
	akx_rsp_if.source rsp
);
	import akx_pkg::*;

	akx_cmd_t  cmd;
	akx_stat_t stat;

	// sequencer
	akx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// key schedule, stores and output register
	akx_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (req.func),
		.round_index  (req.round_index),
		.key_w0       (req.key_w0),
		.key_w1       (req.key_w1),
		.key_w2       (req.key_w2),
		.key_w3       (req.key_w3),
		.round_key_hi (rsp.round_key_hi),
		.round_key_lo (rsp.round_key_lo)
	);
endmodule

/* hw/rtl/akx_ctrl.sv */
module akx_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  akx_pkg::akx_stat_t stat,
	output akx_pkg::akx_cmd_t  cmd
);
	import akx_pkg::*;

	akx_state_t       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             out_valid_q, out_valid_d;
	logic             slot_free;

	// state, word counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		out_valid_d   = out_valid_q && !out_ready;
		cmd           = '0;
		cmd.word_idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					idx_d       = '0;
					state_d     = stat.expand_req ? ST_KEY : ST_READ;
				end
			end
			ST_KEY: begin
				cmd.key_write = 1'b1;
				if (idx_q == LAST_KEY_ROW) begin
					idx_d   = FIRST_GEN;
					state_d = ST_GEN;
				end else begin
					idx_d = idx_q + IDX_W'(4);
				end
			end
			ST_GEN: begin
				cmd.gen_step = 1'b1;
				if (idx_q == LAST_WORD) begin
					state_d = ST_READ;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

/* hw/rtl/akx_datapath.sv */
module akx_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  akx_pkg::akx_cmd_t  cmd,
	output akx_pkg::akx_stat_t stat,
	input  logic               func,
	input  logic [3:0]         round_index,
	input  logic [63:0]        key_w0,
	input  logic [63:0]        key_w1,
	input  logic [63:0]        key_w2,
	input  logic [63:0]        key_w3,
	output logic [63:0]        round_key_hi,
	output logic [63:0]        round_key_lo
);
	import akx_pkg::*;

	logic [31:0]       w_q [KEY_WORDS];
	logic [7:0]        rcon_q;
	logic              dir_q;
	logic [ROW_W-1:0]  round_q;
	logic [1:0]        expanded_q;
	logic [63:0]       hi_mem [MEM_DEPTH];
	logic [63:0]       lo_mem [MEM_DEPTH];
	logic [63:0]       rd_hi_q, rd_lo_q;
	logic [63:0]       out_hi_q, out_lo_q;
	logic [31:0]       t_word, new_word;
	logic [2:0]        k_lo, k_hi;
	logic [63:0]       key_hi, key_lo;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              hit;

	// expansion needed: forward round zero or inverse last round
	assign stat.expand_req = (func == FUNC_FWD && round_index == 4'd0) ||
		(func == FUNC_INV && round_index == 4'(NUM_ROUNDS));

	// next schedule word from the eight-word window
	always_comb begin
		t_word = w_q[KEY_WORDS-1];
		case (cmd.word_idx[2:0])
			3'd0:    t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_q, 24'h0};
			3'd4:    t_word = sub_word(t_word);
			default: t_word = w_q[KEY_WORDS-1];
		endcase
		new_word = w_q[0] ^ t_word;
	end

	// original key words, one row of both halves per cycle
	assign k_hi   = {cmd.word_idx[2], 2'b00};
	assign k_lo   = {cmd.word_idx[2], 2'b10};
	assign key_hi = {w_q[k_hi], w_q[k_hi + 3'd1]};
	assign key_lo = {w_q[k_lo], w_q[k_lo + 3'd1]};

	assign wr_addr = {dir_q, cmd.word_idx[IDX_W-1:2]};
	assign rd_addr = {dir_q, round_q};

	// request capture and key window
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dir_q   <= func;
			round_q <= round_index;
			rcon_q  <= 8'h01;
			w_q[0]  <= key_w0[63:32];
			w_q[1]  <= key_w0[31:0];
			w_q[2]  <= key_w1[63:32];
			w_q[3]  <= key_w1[31:0];
			w_q[4]  <= key_w2[63:32];
			w_q[5]  <= key_w2[31:0];
			w_q[6]  <= key_w3[63:32];
			w_q[7]  <= key_w3[31:0];
		end else if (cmd.gen_step) begin
			for (int j = 0; j < KEY_WORDS - 1; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[KEY_WORDS-1] <= new_word;
			if (cmd.word_idx[2:0] == 3'd0) begin
				rcon_q <= xtime(rcon_q);
			end
		end
	end

	// a direction reads as zero until its first expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expanded_q <= '0;
		end else if (cmd.capture && stat.expand_req) begin
			expanded_q[func] <= 1'b1;
		end
	end

	// round key stores, hi and lo halves side by side
	always_ff @(posedge clk) begin
		if (cmd.key_write) begin
			hi_mem[wr_addr] <= key_hi;
			lo_mem[wr_addr] <= key_lo;
		end else if (cmd.gen_step && cmd.word_idx[0]) begin
			if (!cmd.word_idx[1]) begin
				hi_mem[wr_addr] <= {w_q[KEY_WORDS-1], new_word};
			end else begin
				lo_mem[wr_addr] <= {w_q[KEY_WORDS-1], new_word};
			end
		end
		if (cmd.mem_read) begin
			rd_hi_q <= hi_mem[rd_addr];
			rd_lo_q <= lo_mem[rd_addr];
		end
	end

	// output register
	assign hit = expanded_q[dir_q] && (round_q <= LAST_ROUND);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hi_q <= hit ? rd_hi_q : 64'h0;
			out_lo_q <= hit ? rd_lo_q : 64'h0;
		end
	end

	assign round_key_hi = out_hi_q;
	assign round_key_lo = out_lo_q;
endmodule

/* hw/rtl/akx_checker.sv */
module akx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_hi,
	input logic [63:0] rsp_lo
);
	logic [1:0] pending_q;
	logic       req_fire, rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_fire) - 2'(rsp_fire);
		end
	end

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hi) && $stable(rsp_lo))
		else $error("stalled response changed");

	// no response without an open request
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without request");

	// at most one request in work beside one waiting result
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many open requests");

	// busy while one result waits and another is in work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd2 |-> !req_ready)
		else $error("request taken while full");
endmodule

bind aes256_round_key_expansion akx_checker u_akx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_hi    (rsp.round_key_hi),
	.rsp_lo    (rsp.round_key_lo)
);

/* tb/sv/tb_aes256_round_key_expansion.sv */
`timescale 1ns / 1ps

module tb_aes256_round_key_expansion;
	import akx_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int CALM_START   = 300;
	localparam int CALM_LEN     = 80;
	localparam int CALM_TAIL    = 100;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 80;

	// one request on the key channel
	typedef struct packed {
		logic         func;
		logic [3:0]   round_index;
		logic [255:0] key;
	} key_req_t;

	// directed row, with a typed-in round key where one is obvious
	typedef struct packed {
		key_req_t     rq;
		logic         typed;
		logic [127:0] want;
	} dir_row_t;

	localparam logic [255:0] KEY_ZERO = '0;
	localparam logic [255:0] KEY_ONES = '1;
	localparam logic [255:0] KEY_FIPS =
		256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;

	logic clk;
	logic arst_n;

	akx_req_if req_ch ();
	akx_rsp_if rsp_ch ();

	aes256_round_key_expansion u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predicted key schedules, one per direction
	logic [63:0]  fwd_sched [2*(NUM_ROUNDS+1)];
	logic [63:0]  inv_sched [2*(NUM_ROUNDS+1)];
	logic [127:0] pending_round_keys [$];
	int           mismatch_count;
	bit           traffic_gaps;
	dir_row_t     dir_tab [$];

	// clock and reset
	initial clk = 1'b0;

	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// gf(2^8) multiply, aes polynomial
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		int k;
		p = '0;
		x = a;
		for (k = 0; k < 8; k++) begin
			if (b[k])
				p ^= x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// s-box byte: inverse as x^254, then affine map
	function automatic logic [7:0] sbox_byte(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] base;
		logic [7:0] e;
		int k;
		r = 8'h01;
		base = x;
		e = 8'd254;
		for (k = 0; k < 8; k++) begin
			if (e[k])
				r = gf_mul(r, base);
			base = gf_mul(base, base);
		end
		return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
			^ 8'h63;
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {sbox_byte(w[31:24]), sbox_byte(w[23:16]), sbox_byte(w[15:8]),
			sbox_byte(w[7:0])};
	endfunction

	// full aes-256 schedule into the store of one direction
	task automatic expand_schedule(input logic [255:0] key, input logic func);
		logic [31:0] w [4*(NUM_ROUNDS+1)];
		logic [31:0] t;
		logic [7:0]  rcon;
		int i;
		rcon = 8'h01;
		for (i = 0; i < KEY_WORDS; i++)
			w[i] = key[255-32*i -: 32];
		for (i = KEY_WORDS; i < 4*(NUM_ROUNDS+1); i++) begin
			t = w[i-1];
			if (i % KEY_WORDS == 0) begin
				t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
				rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
			end else if (i % KEY_WORDS == 4) begin
				t = sbox_word(t);
			end
			w[i] = w[i-KEY_WORDS] ^ t;
		end
		for (i = 0; i < 2*(NUM_ROUNDS+1); i++) begin
			if (func == FUNC_INV)
				inv_sched[i] = {w[2*i], w[2*i+1]};
			else
				fwd_sched[i] = {w[2*i], w[2*i+1]};
		end
	endtask

	// expected round key for one accepted request, updates the store when the request expands
	task automatic predict_round_key(input key_req_t rq, output logic [127:0] rk);
		int idx;
		idx = 2 * int'(rq.round_index);
		if (rq.round_index > NUM_ROUNDS) begin
			rk = '0;
		end else begin
			if (rq.func == FUNC_FWD && rq.round_index == 0)
				expand_schedule(rq.key, FUNC_FWD);
			else if (rq.func == FUNC_INV && rq.round_index == NUM_ROUNDS)
				expand_schedule(rq.key, FUNC_INV);
			if (rq.func == FUNC_INV)
				rk = {inv_sched[idx], inv_sched[idx+1]};
			else
				rk = {fwd_sched[idx], fwd_sched[idx+1]};
		end
	endtask

	function automatic dir_row_t dir_row(input logic f, input logic [3:0] r,
		input logic [255:0] k, input logic typed, input logic [127:0] want);
		dir_row_t row;
		row.rq.func = f;
		row.rq.round_index = r;
		row.rq.key = k;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic logic [255:0] rand_key();
		logic [255:0] k;
		int i;
		k = '0;
		case ($urandom_range(0, 7))
			0: k = KEY_ZERO;
			1: k = KEY_ONES;
			default: begin
				for (i = 0; i < 8; i++)
					k = {k[223:0], 32'($urandom)};
			end
		endcase
		return k;
	endfunction

	// drive one transaction, predict it on acceptance
	task automatic send_key_req(input key_req_t rq, input logic typed, input logic [127:0] want);
		logic [127:0] rk;
		if (traffic_gaps && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= rq.func;
		req_ch.round_index <= rq.round_index;
		req_ch.key_w0      <= rq.key[255:192];
		req_ch.key_w1      <= rq.key[191:128];
		req_ch.key_w2      <= rq.key[127:64];
		req_ch.key_w3      <= rq.key[63:0];
		do @(posedge clk); while (!req_ch.ready);
		predict_round_key(rq, rk);
		pending_round_keys.push_back(typed ? want : rk);
	endtask

	// response side backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (traffic_gaps && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 7);
			end
		end
	end

	// check each response transaction against the oldest expectation
	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_round_keys.size() == 0) begin
				$error("unexpected round key: hi %h lo %h", rsp_ch.round_key_hi,
					rsp_ch.round_key_lo);
				mismatch_count++;
			end else begin
				want = pending_round_keys.pop_front();
				if (rsp_ch.round_key_hi !== want[127:64]) begin
					$error("round_key_hi: expected %h, actual %h", want[127:64],
						rsp_ch.round_key_hi);
					mismatch_count++;
				end
				if (rsp_ch.round_key_lo !== want[63:0]) begin
					$error("round_key_lo: expected %h, actual %h", want[63:0],
						rsp_ch.round_key_lo);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// stimulus
	initial begin
		key_req_t rq;
		int n;
		int pick;
		mismatch_count = 0;
		traffic_gaps = 1'b1;
		for (n = 0; n < 2*(NUM_ROUNDS+1); n++) begin
			fwd_sched[n] = '0;
			inv_sched[n] = '0;
		end
		req_ch.valid       <= 1'b0;
		req_ch.func        <= FUNC_FWD;
		req_ch.round_index <= '0;
		req_ch.key_w0      <= '0;
		req_ch.key_w1      <= '0;
		req_ch.key_w2      <= '0;
		req_ch.key_w3      <= '0;

		// lookups after reset, out of range, zero and known keys, both directions
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd5,  KEY_ZERO, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd3,  KEY_ONES, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd0,  KEY_FIPS, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd15, KEY_ONES, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd15, KEY_ONES, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd0,  KEY_ZERO, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd1,  KEY_ONES, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd14, KEY_ONES, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd0,  KEY_FIPS, 1'b1,
			128'h000102030405060708090a0b0c0d0e0f));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd1,  KEY_ZERO, 1'b1,
			128'h101112131415161718191a1b1c1d1e1f));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd2,  KEY_ZERO, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd13, KEY_ONES, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd14, KEY_ZERO, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd14, KEY_ONES, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd0,  KEY_ZERO, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd7,  KEY_FIPS, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd15, KEY_FIPS, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd15, KEY_ZERO, 1'b1, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd7,  KEY_ONES, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd14, KEY_FIPS, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_INV, 4'd1,  KEY_ONES, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd0,  KEY_ONES, 1'b0, '0));
		dir_tab.push_back(dir_row(FUNC_FWD, 4'd14, KEY_ZERO, 1'b0, '0));

		@(posedge arst_n);
		@(posedge clk);

		// directed table
		foreach (dir_tab[i])
			send_key_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

		// random part: expansions and lookups mixed, plus out of range noise
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			traffic_gaps = !((n >= CALM_START && n < CALM_START + CALM_LEN) ||
				n >= RANDOM_ITEMS - CALM_TAIL);
			pick = $urandom_range(0, 99);
			rq.func = $urandom_range(0, 1) ? FUNC_INV : FUNC_FWD;
			rq.key = rand_key();
			if (pick < 18)
				rq.round_index = (rq.func == FUNC_INV) ? LAST_ROUND : 4'd0;
			else if (pick < 24)
				rq.round_index = 4'd15;
			else
				rq.round_index = 4'($urandom_range(0, NUM_ROUNDS));
			send_key_req(rq, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		// drain
		while (pending_round_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_round_keys.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
